// ----- rtl/core/table_driven_dfa_recognizer_macros.svh -----
// Assertion macros shared by the checker of the DFA recognizer.
`ifndef TABLE_DRIVEN_DFA_RECOGNIZER_MACROS_SVH
`define TABLE_DRIVEN_DFA_RECOGNIZER_MACROS_SVH

// The consequent must hold at the same edge as the antecedent.
`define TDFA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold at the edge after the antecedent.
`define TDFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/tdfa_pkg.sv -----
`timescale 1ns / 1ps

package tdfa_pkg;

   // Input commands.
   typedef enum logic [1:0] {
      CMD_ALPHA  = 2'd0,
      CMD_TRANS  = 2'd1,
      CMD_FEED   = 2'd2,
      CMD_FINISH = 2'd3
   } cmd_type;

   // Verdict codes; the stuck codes double as the stored stuck state.
   localparam logic [1:0] VERDICT_ACCEPT    = 2'd0;
   localparam logic [1:0] VERDICT_REJECT    = 2'd1;
   localparam logic [1:0] VERDICT_NO_TRANS  = 2'd2;
   localparam logic [1:0] VERDICT_UNKNOWN   = 2'd3;
   localparam logic [1:0] STUCK_NONE        = 2'd0;

   // Result kinds.
   localparam logic KIND_TRACE   = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_START_STATE    = 2'd0;
   localparam logic [1:0] CSR_ACCEPT_MASK    = 2'd1;
   localparam logic [1:0] CSR_SYMBOLS_IN_USE = 2'd2;

   // Field widths fixed by the interface.
   localparam int unsigned STATE_W = 4;
   localparam int unsigned SLOT_W  = 4;
   localparam int unsigned BYTE_W  = 8;

   // One transition table entry.
   typedef struct packed {
      logic               valid;
      logic [STATE_W-1:0] target;
   } entry_type;

   // Outcome of the alphabet match.
   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
   } match_type;

endpackage

// ----- rtl/core/tdfa_alphabet.sv -----
`timescale 1ns / 1ps

module tdfa_alphabet #(
   parameter int unsigned NUM_SLOTS = 16
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(NUM_SLOTS)-1:0] wr_index,
   input  logic [7:0]                   wr_byte,
   input  logic [7:0]                   match_byte,
   input  logic [4:0]                   match_limit,
   output tdfa_pkg::match_type          match
);
   import tdfa_pkg::*;

   logic [BYTE_W-1:0] alpha_ff [NUM_SLOTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         alpha_ff[wr_index] <= wr_byte;
      end
   end

   // Parallel compare; walking down from the top leaves the lowest hit.
   always_comb begin
      match = '0;
      for (int j = NUM_SLOTS - 1; j >= 0; j--) begin
         if ((5'(j) < match_limit) && (alpha_ff[j] == match_byte)) begin
            match.hit  = 1'b1;
            match.slot = SLOT_W'(j);
         end
      end
   end

endmodule

// ----- rtl/core/tdfa_table_ram.sv -----
`timescale 1ns / 1ps

module tdfa_table_ram #(
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  tdfa_pkg::entry_type      wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output tdfa_pkg::entry_type      rd_data
);
   import tdfa_pkg::*;

   entry_type table_mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/table_driven_dfa_recognizer.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Ports                                    Transfer when
// req       in         req_cmd, req_symbol, req_slot,           req_valid & req_ready
//                      req_row_state, req_target_state,
//                      req_target_valid
// rsp       out        rsp_kind, rsp_current_state, rsp_verdict rsp_valid & rsp_ready
// csr       in         csr_index, csr_wdata                     csr_wen
//
// Alphabet and transition writes produce no result and do not hold off the next item.
// A finish or a symbol taken while not stuck occupies the resolve stage; a symbol's transition
// memory read is issued at the transfer edge, and the present state is only known after it.
// Reset is synchronous and active high; it clears the control state and the
// configuration registers, but not the alphabet or the transition memory.
// A stalled result sits in the output register while a new item is taken; the
// stage behind it holds until the output register frees up.

module table_driven_dfa_recognizer #(
   parameter int unsigned NUM_STATES  = 16,
   parameter int unsigned NUM_SYMBOLS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Input items.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_symbol,
   input  logic [3:0]  req_slot,
   input  logic [3:0]  req_row_state,
   input  logic [3:0]  req_target_state,
   input  logic        req_target_valid,
   // Result items.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [3:0]  rsp_current_state,
   output logic [1:0]  rsp_verdict,
   // Configuration writes.
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import tdfa_pkg::*;

   // The transition memory holds one entry per (state, slot) pair, row-major.
   localparam int unsigned DEPTH   = NUM_STATES * NUM_SYMBOLS;
   localparam int unsigned AW      = $clog2(DEPTH);
   // Only the first sixteen slots can ever be named by a four-bit slot field.
   localparam int unsigned ALPHA_N = (NUM_SYMBOLS < 16) ? NUM_SYMBOLS : 16;
   localparam int unsigned AIW     = $clog2(ALPHA_N);

   // Configuration registers.
   logic [STATE_W-1:0] start_state_ff, start_state_in;
   logic [15:0]        accept_mask_ff, accept_mask_in;
   logic [4:0]         symbols_in_use_ff, symbols_in_use_in;

   // Recognizer state.
   logic [STATE_W-1:0] present_state_ff, present_state_in;
   logic [1:0]         stuck_ff, stuck_in;

   // Resolve stage: holds an accepted symbol, with its memory read pending, or a finish.
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_finish_ff, s1_finish_in;
   logic               s1_hit_ff, s1_hit_in;
   logic               s1_inrange_ff, s1_inrange_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [STATE_W-1:0] rsp_state_ff, rsp_state_in;
   logic [1:0]         rsp_verdict_ff, rsp_verdict_in;

   logic               accept;
   logic               load_s1;
   logic               s1_go;
   logic               is_feed;
   logic               is_finish;
   logic               alpha_wr;
   logic               table_wr;
   logic [31:0]        wr_addr_full;
   logic [31:0]        rd_addr_full;
   logic [AW-1:0]      wr_addr;
   logic [AW-1:0]      rd_addr;
   entry_type          wr_entry;
   entry_type          rd_entry;
   match_type          match;

   logic               res_kind;
   logic [STATE_W-1:0] res_state;
   logic [1:0]         res_verdict;
   logic [STATE_W-1:0] res_next_state;
   logic [1:0]         res_next_stuck;

   // The present state is only settled once the resolve stage has drained, so a
   // new item is taken only then.
   assign req_ready = !s1_valid_ff;
   assign accept    = req_valid && req_ready;
   assign is_feed   = (req_cmd == CMD_FEED);
   assign is_finish = (req_cmd == CMD_FINISH);

   // Writes outside the configured table size are dropped.
   assign alpha_wr = accept && (req_cmd == CMD_ALPHA) && (32'(req_slot) < NUM_SYMBOLS);
   assign table_wr = accept && (req_cmd == CMD_TRANS) && (32'(req_slot) < NUM_SYMBOLS)
                     && (32'(req_row_state) < NUM_STATES);

   // A symbol that arrives while the recognizer is stuck is dropped without a result.
   assign load_s1 = accept && ((is_feed && (stuck_ff == STUCK_NONE)) || is_finish);

   // The resolve stage hands over whenever the output register is free or draining.
   assign s1_go = s1_valid_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      wr_addr_full    = 32'(req_row_state) * 32'(NUM_SYMBOLS) + 32'(req_slot);
      rd_addr_full    = 32'(present_state_ff) * 32'(NUM_SYMBOLS) + 32'(match.slot);
      wr_addr         = wr_addr_full[AW-1:0];
      rd_addr         = rd_addr_full[AW-1:0];
      wr_entry.valid  = req_target_valid;
      wr_entry.target = req_target_state;
   end

   tdfa_alphabet #(
      .NUM_SLOTS (ALPHA_N)
   ) u_alphabet (
      .clock       (clock),
      .wr_en       (alpha_wr),
      .wr_index    (req_slot[AIW-1:0]),
      .wr_byte     (req_symbol),
      .match_byte  (req_symbol),
      .match_limit (symbols_in_use_ff),
      .match       (match)
   );

   tdfa_table_ram #(
      .DEPTH (DEPTH)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (table_wr),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (accept && is_feed),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   // Stage one captures what the step needs besides the memory word: whether the
   // byte matched a slot and whether the present state has a table row at all.
   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_finish_in  = s1_finish_ff;
      s1_hit_in     = s1_hit_ff;
      s1_inrange_in = s1_inrange_ff;
      if (load_s1) begin
         s1_valid_in   = 1'b1;
         s1_finish_in  = is_finish;
         s1_hit_in     = match.hit;
         s1_inrange_in = (32'(present_state_ff) < NUM_STATES);
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   // Resolve the step from the memory word, or the finish from the accept mask and stuck state.
   always_comb begin
      res_kind       = KIND_TRACE;
      res_state      = present_state_ff;
      res_verdict    = VERDICT_ACCEPT;
      res_next_state = present_state_ff;
      res_next_stuck = stuck_ff;
      if (s1_finish_ff) begin
         res_kind = KIND_VERDICT;
         if (stuck_ff != STUCK_NONE) begin
            res_verdict = stuck_ff;
         end else if (accept_mask_ff[present_state_ff]) begin
            res_verdict = VERDICT_ACCEPT;
         end else begin
            res_verdict = VERDICT_REJECT;
         end
         res_next_state = start_state_ff;
         res_next_stuck = STUCK_NONE;
      end else if (!s1_hit_ff) begin
         res_verdict    = VERDICT_UNKNOWN;
         res_next_stuck = VERDICT_UNKNOWN;
      end else if (!(s1_inrange_ff && rd_entry.valid)) begin
         res_verdict    = VERDICT_NO_TRANS;
         res_next_stuck = VERDICT_NO_TRANS;
      end else begin
         res_state      = rd_entry.target;
         res_next_state = rd_entry.target;
      end
   end

   always_comb begin
      present_state_in = present_state_ff;
      stuck_in         = stuck_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_kind_in      = rsp_kind_ff;
      rsp_state_in     = rsp_state_ff;
      rsp_verdict_in   = rsp_verdict_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_go) begin
         present_state_in = res_next_state;
         stuck_in         = res_next_stuck;
         rsp_valid_in     = 1'b1;
         rsp_kind_in      = res_kind;
         rsp_state_in     = res_state;
         rsp_verdict_in   = res_verdict;
      end
   end

   // Configuration writes; an index past the last register is ignored.
   always_comb begin
      start_state_in    = start_state_ff;
      accept_mask_in    = accept_mask_ff;
      symbols_in_use_in = symbols_in_use_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_START_STATE: begin
               start_state_in = csr_wdata[STATE_W-1:0];
            end
            CSR_ACCEPT_MASK: begin
               accept_mask_in = csr_wdata;
            end
            CSR_SYMBOLS_IN_USE: begin
               symbols_in_use_in = csr_wdata[4:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_state_ff    <= '0;
         accept_mask_ff    <= '0;
         symbols_in_use_ff <= '0;
         present_state_ff  <= '0;
         stuck_ff          <= STUCK_NONE;
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         start_state_ff    <= start_state_in;
         accept_mask_ff    <= accept_mask_in;
         symbols_in_use_ff <= symbols_in_use_in;
         present_state_ff  <= present_state_in;
         stuck_ff          <= stuck_in;
         s1_valid_ff       <= s1_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      s1_finish_ff   <= s1_finish_in;
      s1_hit_ff      <= s1_hit_in;
      s1_inrange_ff  <= s1_inrange_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_state_ff   <= rsp_state_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_current_state = rsp_state_ff;
   assign rsp_verdict       = rsp_verdict_ff;

endmodule

// ----- rtl/core/tdfa_checker.sv -----
`timescale 1ns / 1ps
`include "table_driven_dfa_recognizer_macros.svh"

module tdfa_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_cmd,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_kind,
   input logic [3:0] rsp_current_state,
   input logic [1:0] rsp_verdict
);
   import tdfa_pkg::*;

   `TDFA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_current_state) && $stable(rsp_verdict), "result changed while stalled")
   `TDFA_ASSERT_NOW(a_reset_clean, clock, reset, $past(reset), !rsp_valid && req_ready, "not idle after reset")
   `TDFA_ASSERT_NEXT(a_finish_busy, clock, reset, req_valid && req_ready && req_cmd == CMD_FINISH, !req_ready, "finish did not occupy the resolve stage")
   `TDFA_ASSERT_NEXT(a_write_silent, clock, reset, req_valid && req_ready && (req_cmd == CMD_ALPHA || req_cmd == CMD_TRANS) && !rsp_valid, !rsp_valid, "table write produced a result")
   `TDFA_ASSERT_NOW(a_trace_verdict, clock, reset, rsp_valid && rsp_kind == KIND_TRACE, rsp_verdict != VERDICT_REJECT, "step trace carries a finish verdict")

endmodule

bind table_driven_dfa_recognizer tdfa_checker u_tdfa_checker (.*);
